@@ hw/rtl/i2c_master_byte_engine_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the two-wire bus master byte engine
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH

// Condition that must hold at every clock edge out of reset
`define I2CME_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Same-cycle implication
`define I2CME_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/i2cme_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cme_pkg
// Command codes, line bit positions and phase decode for the byte engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cme_pkg;

  // Command codes (input action field)
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;
  localparam logic [2:0] CMD_ACK   = 3'd5;

  // Bit positions in the line level vector
  localparam int LN_SCL = 0;
  localparam int LN_SDA = 1;
  localparam int LN_IN  = 2;

  localparam int          PHASE_W     = 5;
  localparam logic [15:0] PHASE_TICKS_RST = 16'd10;
  localparam logic [2:0]  LINES_RST   = 3'b010;   // clock low, data high, driven

  typedef logic [2:0]         lines_t;
  typedef logic [PHASE_W-1:0] phase_t;

  // Number of phases of each command
  function automatic phase_t phase_count(input logic [2:0] cmd);
    phase_t n;
    unique case (cmd)
      CMD_START: n = 5'd3;
      CMD_STOP:  n = 5'd4;
      CMD_WRITE: n = 5'd19;
      CMD_READ:  n = 5'd25;
      CMD_ACK:   n = 5'd2;
      default:   n = 5'd0;
    endcase
    return n;
  endfunction

  // Phase index modulo three (2^k mod 3 alternates 1, 2)
  function automatic logic [1:0] phase_mod3(input phase_t p);
    logic [2:0] s;
    logic [1:0] r;
    s = {2'b0, p[0]} + {2'b0, p[2]} + {2'b0, p[4]} + {1'b0, p[1], 1'b0}
      + {1'b0, p[3], 1'b0};
    unique case (s)
      3'd0, 3'd3, 3'd6: r = 2'd0;
      3'd1, 3'd4, 3'd7: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // Line levels on entry to phase p; p equal to the count is completion
  function automatic lines_t enter_phase(input logic [2:0] cmd, input phase_t p,
                                         input logic [7:0] shift, input lines_t lines);
    lines_t l;
    l = lines;
    unique case (cmd)
      CMD_START: begin
        if (p == 5'd0) begin
          l[LN_SCL] = 1'b0;
          l[LN_SDA] = 1'b1;
        end else if (p == 5'd1) l[LN_SCL] = 1'b1;
        else if (p == 5'd2) l[LN_SDA] = 1'b0;
        else l[LN_SCL] = 1'b0;
      end
      CMD_STOP: begin
        if (p == 5'd0) l[LN_SCL] = 1'b0;
        else if (p == 5'd1) l[LN_SDA] = 1'b0;
        else if (p == 5'd2) l[LN_SCL] = 1'b1;
        else if (p == 5'd3) l[LN_SDA] = 1'b1;
        else l[LN_SCL] = 1'b0;
      end
      CMD_ACK: begin
        if (p == 5'd0) begin
          l[LN_SCL] = 1'b0;
          l[LN_SDA] = ~shift[0];
        end else if (p == 5'd1) l[LN_SCL] = 1'b1;
        else l[LN_SCL] = 1'b0;
      end
      CMD_WRITE: begin
        if (p < 5'd16) begin
          if (!p[0]) begin
            l[LN_SCL] = 1'b0;
            l[LN_SDA] = shift[3'd7 - p[3:1]];   // MSB first
          end else l[LN_SCL] = 1'b1;
        end else if (p == 5'd16) l[LN_SCL] = 1'b0;
        else if (p == 5'd17) l[LN_SDA] = 1'b1;  // release for the ack slot
        else if (p == 5'd18) l[LN_SCL] = 1'b1;
        else l[LN_SCL] = 1'b0;
      end
      CMD_READ: begin
        if (p == 5'd0 || p == 5'd2) l[LN_SCL] = 1'b0;
        else if (p == 5'd1) begin
          l[LN_SDA] = 1'b1;
          l[LN_IN]  = 1'b1;
        end else if (p >= 5'd25) begin
          l[LN_SCL] = 1'b0;
          l[LN_IN]  = 1'b0;
        end else l[LN_SCL] = (phase_mod3(p) != 2'd2);
      end
      default: l = lines;
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/i2c_master_byte_engine.sv @@
// The result word is registered and offered in the cycle after the accept.
// Throughput: one word per cycle while a pending result is taken;
// each word is one bus tick; phase and tick counters update on accept.
// Reset (rst_n low, synchronous): idle, clock low, data high and driven,
// last read byte zero, phase length 10 ticks, no result word pending.
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Two-wire bus master that steps start, stop, write, read and acknowledge
// sequences one tick per input word, each bus phase lasting phase_ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_master_byte_engine_assert.svh"

module i2c_master_byte_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: phase_ticks
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  // input words
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [2:0] action, [10:3] write_byte, [11] ack_level, [12] sda_sample
  input  wire logic [15:0] in_tdata,
  // result words
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] scl_level, [1] sda_level, [2] sda_is_input, [3] busy_res,
  // [11:4] read_byte, [12] read_done
  output logic [15:0]      out_tdata
);

  // State
  logic [15:0]           phase_ticks_r;
  logic [2:0]            cmd_r, cmd_nxt;
  i2cme_pkg::phase_t     phase_r, phase_nxt;
  logic [15:0]           tick_r, tick_nxt;
  logic [7:0]            shift_r, shift_nxt;
  i2cme_pkg::lines_t     lines_r, lines_nxt;
  logic [7:0]            last_read_r, last_read_nxt;
  logic                  out_valid_r;
  logic [15:0]           out_data_r, out_data_nxt;

  // Input word fields
  logic [2:0] action;
  logic [7:0] write_byte;
  logic       ack_level;
  logic       sda_sample;

  // Per-word working values
  logic              start_cmd;
  logic [2:0]        cmd_a;
  i2cme_pkg::phase_t phase_a, phase_inc;
  logic [15:0]       tick_a;
  logic [7:0]        shift_a, shift_s;
  i2cme_pkg::lines_t lines_a, lines_e;
  logic [16:0]       tick_inc, limit;
  logic              phase_end, sample_bit, cmd_end, done, busy;
  logic              in_acc;

  assign action     = in_tdata[2:0];
  assign write_byte = in_tdata[10:3];
  assign ack_level  = in_tdata[11];
  assign sda_sample = in_tdata[12];

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // Command entry: takes effect on the tick it is given
  always_comb begin
    start_cmd = (cmd_r == i2cme_pkg::CMD_NONE) &&
                (action >= i2cme_pkg::CMD_START) && (action <= i2cme_pkg::CMD_ACK);
    cmd_a   = start_cmd ? action : cmd_r;
    phase_a = start_cmd ? '0 : phase_r;
    tick_a  = start_cmd ? '0 : tick_r;
    shift_a = shift_r;
    if (start_cmd) begin
      priority if (action == i2cme_pkg::CMD_WRITE) shift_a = write_byte;
      else if (action == i2cme_pkg::CMD_ACK) shift_a = {7'd0, ack_level};
      else if (action == i2cme_pkg::CMD_READ) shift_a = '0;
      else shift_a = shift_r;
    end
    lines_a = start_cmd ? i2cme_pkg::enter_phase(cmd_a, '0, shift_a, lines_r) : lines_r;
    busy    = (cmd_a != i2cme_pkg::CMD_NONE);
  end

  // Tick counter and phase advance
  always_comb begin
    limit      = {1'b0, (phase_ticks_r == 16'd0) ? 16'd1 : phase_ticks_r};
    tick_inc   = {1'b0, tick_a} + 17'd1;
    phase_end  = busy && (tick_inc >= limit);
    phase_inc  = phase_a + 5'd1;
    sample_bit = (cmd_a == i2cme_pkg::CMD_READ) && (phase_a >= 5'd3) &&
                 (i2cme_pkg::phase_mod3(phase_a) == 2'd0);
    shift_s    = (phase_end && sample_bit) ? {shift_a[6:0], sda_sample} : shift_a;
    lines_e    = i2cme_pkg::enter_phase(cmd_a, phase_inc, shift_s, lines_a);
    cmd_end    = phase_end && (phase_inc >= i2cme_pkg::phase_count(cmd_a));
    done       = cmd_end && (cmd_a == i2cme_pkg::CMD_READ);

    tick_nxt      = busy ? (phase_end ? 16'd0 : tick_inc[15:0]) : tick_a;
    shift_nxt     = shift_s;
    lines_nxt     = phase_end ? lines_e : lines_a;
    cmd_nxt       = cmd_end ? i2cme_pkg::CMD_NONE : cmd_a;
    phase_nxt     = cmd_end ? '0 : (phase_end ? phase_inc : phase_a);
    last_read_nxt = done ? shift_s : last_read_r;

    out_data_nxt  = {3'd0, done, last_read_nxt, busy,
                     lines_a[i2cme_pkg::LN_IN], lines_a[i2cme_pkg::LN_SDA],
                     lines_a[i2cme_pkg::LN_SCL]};
  end

  // Sequencer state, advanced once per accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= i2cme_pkg::PHASE_TICKS_RST;
      cmd_r         <= i2cme_pkg::CMD_NONE;
      phase_r       <= '0;
      tick_r        <= '0;
      shift_r       <= '0;
      lines_r       <= i2cme_pkg::LINES_RST;
      last_read_r   <= '0;
    end else begin
      if (cfg_wr_en) phase_ticks_r <= cfg_wr_data;
      if (in_acc) begin
        cmd_r       <= cmd_nxt;
        phase_r     <= phase_nxt;
        tick_r      <= tick_nxt;
        shift_r     <= shift_nxt;
        lines_r     <= lines_nxt;
        last_read_r <= last_read_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Assertions
  `I2CME_ASSERT_IMPL(a_idle_clear, cmd_r == i2cme_pkg::CMD_NONE,
                     phase_r == '0 && tick_r == '0, "idle with phase or tick left over")
  `I2CME_ASSERT_IMPL(a_phase_bound, cmd_r != i2cme_pkg::CMD_NONE,
                     phase_r < i2cme_pkg::phase_count(cmd_r), "phase index past command end")
  `I2CME_ASSERT_IMPL(a_release_read, lines_r[i2cme_pkg::LN_IN],
                     cmd_r == i2cme_pkg::CMD_READ, "data line released outside a read")
  `I2CME_ASSERT_IMPL(a_done_busy, in_acc && done, busy && cmd_nxt == i2cme_pkg::CMD_NONE,
                     "read done without ending a busy read")

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-wire bus master byte engine. Every input
// word is one bus tick and yields one result word. A tick-level model of the
// phase sequencer predicts the line levels, busy flag and read byte for each
// accepted word. A clocked monitor checks the results in order under random
// back-pressure. The bench steps through several phase lengths, including the
// reset value, zero and both extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  // Action codes the block treats as no command
  localparam logic [2:0] ACT_RSVD6 = 3'd6;
  localparam logic [2:0] ACT_RSVD7 = 3'd7;

  // Levels offered on the data line while the bench stands in for a slave
  localparam int SDA_LOW  = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RAND = 2;

  typedef struct {
    logic [2:0] action;
    logic [7:0] wbyte;
    logic       ack;
    logic       sda;
  } bus_tick_t;

  typedef struct {
    logic       scl;
    logic       sda;
    logic       sda_in;
    logic       busy;
    logic [7:0] rbyte;
    logic       done;
  } line_view_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // [2:0] action, [10:3] write_byte, [11] ack_level, [12] sda_sample
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [15:0] out_tdata;       // [0] scl, [1] sda, [2] sda_is_input, [3] busy, [11:4] read_byte,
                                // [12] read_done

  i2c_master_byte_engine DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Ticks waiting to be offered, and line views waiting to be seen
  bus_tick_t  tick_queue[$];
  line_view_t expected_lines[$];
  int         fail_count = 0;

  // Engine model state, reset values
  logic [15:0] phase_len = i2cme_pkg::PHASE_TICKS_RST;
  logic [2:0]  eng_cmd = i2cme_pkg::CMD_NONE;
  int          eng_phase = 0;
  int          eng_ticks = 0;
  logic [7:0]  eng_shift = '0;
  logic [2:0]  eng_lines = i2cme_pkg::LINES_RST;
  logic [7:0]  eng_last = '0;

  function automatic int phases_of(input logic [2:0] cmd);
    case (cmd)
      i2cme_pkg::CMD_START: return 3;
      i2cme_pkg::CMD_STOP:  return 4;
      i2cme_pkg::CMD_WRITE: return 19;
      i2cme_pkg::CMD_READ:  return 25;
      i2cme_pkg::CMD_ACK:   return 2;
      default:              return 0;
    endcase
  endfunction

  // Line changes on entering phase p; p equal to the phase count is completion
  task automatic apply_phase(input int p);
    case (eng_cmd)
      i2cme_pkg::CMD_START: begin
        if (p == 0) begin
          eng_lines[i2cme_pkg::LN_SCL] = 1'b0;
          eng_lines[i2cme_pkg::LN_SDA] = 1'b1;
        end else if (p == 1) eng_lines[i2cme_pkg::LN_SCL] = 1'b1;
        else if (p == 2) eng_lines[i2cme_pkg::LN_SDA] = 1'b0;
        else eng_lines[i2cme_pkg::LN_SCL] = 1'b0;
      end
      i2cme_pkg::CMD_STOP: begin
        if (p == 1) eng_lines[i2cme_pkg::LN_SDA] = 1'b0;
        else if (p == 2) eng_lines[i2cme_pkg::LN_SCL] = 1'b1;
        else if (p == 3) eng_lines[i2cme_pkg::LN_SDA] = 1'b1;
        else eng_lines[i2cme_pkg::LN_SCL] = 1'b0;
      end
      i2cme_pkg::CMD_ACK: begin
        if (p == 0) begin
          eng_lines[i2cme_pkg::LN_SCL] = 1'b0;
          eng_lines[i2cme_pkg::LN_SDA] = ~eng_shift[0];
        end else if (p == 1) eng_lines[i2cme_pkg::LN_SCL] = 1'b1;
        else eng_lines[i2cme_pkg::LN_SCL] = 1'b0;
      end
      i2cme_pkg::CMD_WRITE: begin
        if (p < 16) begin
          if (p % 2 == 0) begin
            eng_lines[i2cme_pkg::LN_SCL] = 1'b0;
            eng_lines[i2cme_pkg::LN_SDA] = eng_shift[7 - p / 2];
          end else eng_lines[i2cme_pkg::LN_SCL] = 1'b1;
        end else if (p == 17) eng_lines[i2cme_pkg::LN_SDA] = 1'b1;   // released for the ack slot
        else if (p == 18) eng_lines[i2cme_pkg::LN_SCL] = 1'b1;
        else eng_lines[i2cme_pkg::LN_SCL] = 1'b0;
      end
      i2cme_pkg::CMD_READ: begin
        if (p == 0 || p == 2) eng_lines[i2cme_pkg::LN_SCL] = 1'b0;
        else if (p == 1) begin
          eng_lines[i2cme_pkg::LN_SDA] = 1'b1;
          eng_lines[i2cme_pkg::LN_IN]  = 1'b1;
        end else if (p >= 25) begin
          eng_lines[i2cme_pkg::LN_SCL] = 1'b0;
          eng_lines[i2cme_pkg::LN_IN]  = 1'b0;
        end else eng_lines[i2cme_pkg::LN_SCL] = ((p - 3) % 3 != 2);
      end
      default: ;
    endcase
  endtask

  // One bus tick: accept a command when idle, report the lines, then advance
  task automatic advance_engine(input bus_tick_t t);
    line_view_t v;
    int         limit;
    if (eng_cmd == i2cme_pkg::CMD_NONE && t.action >= i2cme_pkg::CMD_START &&
        t.action <= i2cme_pkg::CMD_ACK) begin
      eng_cmd   = t.action;
      eng_phase = 0;
      eng_ticks = 0;
      if (t.action == i2cme_pkg::CMD_WRITE) eng_shift = t.wbyte;
      else if (t.action == i2cme_pkg::CMD_ACK) eng_shift = {7'd0, t.ack};
      else if (t.action == i2cme_pkg::CMD_READ) eng_shift = '0;
      apply_phase(0);
    end
    v.scl    = eng_lines[i2cme_pkg::LN_SCL];
    v.sda    = eng_lines[i2cme_pkg::LN_SDA];
    v.sda_in = eng_lines[i2cme_pkg::LN_IN];
    v.busy   = (eng_cmd != i2cme_pkg::CMD_NONE);
    v.done   = 1'b0;
    if (eng_cmd != i2cme_pkg::CMD_NONE) begin
      limit = (phase_len == 0) ? 1 : int'(phase_len);
      eng_ticks++;
      if (eng_ticks >= limit) begin
        eng_ticks = 0;
        // read bits are sampled at the end of the first clock-high phase
        if (eng_cmd == i2cme_pkg::CMD_READ && eng_phase >= 3 && (eng_phase - 3) % 3 == 0)
          eng_shift = {eng_shift[6:0], t.sda};
        eng_phase++;
        apply_phase(eng_phase);
        if (eng_phase >= phases_of(eng_cmd)) begin
          if (eng_cmd == i2cme_pkg::CMD_READ) begin
            eng_last = eng_shift;
            v.done   = 1'b1;
          end
          eng_cmd   = i2cme_pkg::CMD_NONE;
          eng_phase = 0;
        end
      end
    end
    v.rbyte = eng_last;
    expected_lines.push_back(v);
  endtask

  // Driver: offers queued ticks with a random gap before each
  int        in_gap = 0;
  bit        in_calm = 1'b0;
  bus_tick_t in_word;

  always @(posedge clk) begin
    logic offer;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      offer = in_tvalid;
      if (in_tvalid && in_tready) begin
        advance_engine(in_word);
        offer = 1'b0;
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        in_gap = in_calm ? 0 : $urandom_range(0, 3);
      end
      if (!offer) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (tick_queue.size() > 0) begin
          in_word  = tick_queue.pop_front();
          in_tdata <= {3'd0, in_word.sda, in_word.ack, in_word.wbyte, in_word.action};
          offer    = 1'b1;
        end
      end
      in_tvalid <= offer;
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Monitor: checks each result word, stalls at random, and holds off twice
  int  out_gap = 0;
  bit  out_calm = 1'b0;
  int  words_seen = 0;
  int  hold_left = 0;

  always @(posedge clk) begin
    line_view_t want;
    logic       take;
    if (rst_n) begin
      take = out_tready;
      if (out_tvalid && out_tready) begin
        words_seen++;
        if (expected_lines.size() == 0) begin
          $error("result word %0h with no tick outstanding", out_tdata);
          fail_count++;
        end else begin
          want = expected_lines.pop_front();
          check_field("scl_level", want.scl, out_tdata[0]);
          check_field("sda_level", want.sda, out_tdata[1]);
          check_field("sda_is_input", want.sda_in, out_tdata[2]);
          check_field("busy_res", want.busy, out_tdata[3]);
          check_field("read_byte", want.rbyte, out_tdata[11:4]);
          check_field("read_done", want.done, out_tdata[12]);
        end
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        out_gap = out_calm ? 0 : $urandom_range(0, 3);
        // long hold-off so the engine backs up onto its input
        if (words_seen == 150 || words_seen == 500) hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        take = 1'b0;
      end else begin
        take = 1'b1;
      end
      out_tready <= take;
    end
  end

  task automatic push_tick(input logic [2:0] act, input logic [7:0] wb, input logic ack,
                           input logic sda);
    bus_tick_t t;
    t.action = act;
    t.wbyte  = wb;
    t.ack    = ack;
    t.sda    = sda;
    tick_queue.push_back(t);
  endtask

  // A command followed by enough ticks to finish it; a keep >= 0 below that span cuts it short.
  // Filler ticks now and then carry a command, which the busy engine ignores.
  task automatic push_sequence(input logic [2:0] act, input logic [7:0] wb, input logic ack,
                               input int sda_mode, input int keep, inout int count);
    int         span;
    int         i;
    logic [2:0] a;
    logic       s;
    span = phases_of(act) * ((phase_len == 0) ? 1 : int'(phase_len));
    if (span < 1) span = 1;
    if (keep >= 0 && keep < span) span = keep;
    for (i = 0; i < span; i++) begin
      if (i == 0) a = act;
      else a = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(0, 7)) : i2cme_pkg::CMD_NONE;
      if (sda_mode == SDA_LOW) s = 1'b0;
      else if (sda_mode == SDA_HIGH) s = 1'b1;
      else s = 1'($urandom_range(0, 1));
      push_tick(a, (i == 0) ? wb : 8'($urandom), (i == 0) ? ack : 1'($urandom_range(0, 1)), s);
    end
    count += span;
  endtask

  // Wait until every tick is offered and checked; optionally run the engine idle
  task automatic drain(input bit settle);
    bit quiet;
    quiet = 1'b0;
    while (!quiet) begin
      @(negedge clk);
      if (tick_queue.size() == 0 && !in_tvalid && expected_lines.size() == 0) begin
        if (settle && eng_cmd != i2cme_pkg::CMD_NONE)
          push_tick(i2cme_pkg::CMD_NONE, 8'd0, 1'b0, 1'b1);
        else quiet = 1'b1;
      end
    end
  endtask

  task automatic set_phase_len(input logic [15:0] len);
    drain(1'b1);
    repeat (3) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    phase_len = len;
  endtask

  task automatic random_run(input int target);
    int n;
    int pick;
    int junk;
    n = 0;
    junk = 0;
    while (n < target) begin
      pick = $urandom_range(0, 19);
      if (pick < 17) begin
        push_sequence(3'($urandom_range(i2cme_pkg::CMD_START, i2cme_pkg::CMD_ACK)),
                      8'($urandom), 1'($urandom_range(0, 1)), SDA_RAND, -1, n);
      end else if (pick < 19) begin
        // no command: the engine starts nothing and, if idle, only reports its lines
        case ($urandom_range(0, 2))
          0:       push_tick(i2cme_pkg::CMD_NONE, 8'($urandom), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
          1:       push_tick(ACT_RSVD6, 8'($urandom), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
          default: push_tick(ACT_RSVD7, 8'($urandom), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
        endcase
        junk++;
      end else begin
        // cut-off sequence: the next command may land while still busy
        push_sequence(3'($urandom_range(i2cme_pkg::CMD_START, i2cme_pkg::CMD_ACK)),
                      8'($urandom), 1'($urandom_range(0, 1)), SDA_RAND,
                      $urandom_range(1, 6), n);
      end
    end
  endtask

  initial begin
    int n;
    n = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset phase length of ten ticks
    push_sequence(i2cme_pkg::CMD_START, 8'h00, 1'b0, SDA_RAND, -1, n);
    push_sequence(i2cme_pkg::CMD_ACK, 8'h00, 1'b1, SDA_RAND, -1, n);

    // directed, one tick per phase
    set_phase_len(16'd1);
    push_tick(i2cme_pkg::CMD_NONE, 8'hFF, 1'b1, 1'b1);
    push_tick(ACT_RSVD6, 8'h00, 1'b0, 1'b0);
    push_tick(ACT_RSVD7, 8'hFF, 1'b1, 1'b1);
    push_sequence(i2cme_pkg::CMD_START, 8'h00, 1'b0, SDA_HIGH, -1, n);
    push_sequence(i2cme_pkg::CMD_WRITE, 8'hFF, 1'b0, SDA_LOW, -1, n);
    push_sequence(i2cme_pkg::CMD_WRITE, 8'h00, 1'b1, SDA_HIGH, -1, n);
    push_sequence(i2cme_pkg::CMD_ACK, 8'h00, 1'b1, SDA_RAND, -1, n);
    push_sequence(i2cme_pkg::CMD_ACK, 8'hFF, 1'b0, SDA_RAND, -1, n);
    push_sequence(i2cme_pkg::CMD_READ, 8'h00, 1'b0, SDA_HIGH, -1, n);
    push_sequence(i2cme_pkg::CMD_READ, 8'hFF, 1'b1, SDA_LOW, -1, n);
    // command while busy is dropped
    push_sequence(i2cme_pkg::CMD_WRITE, 8'hA5, 1'b0, SDA_RAND, 2, n);
    push_tick(i2cme_pkg::CMD_STOP, 8'h00, 1'b0, 1'b1);
    push_tick(i2cme_pkg::CMD_READ, 8'h00, 1'b0, 1'b1);
    drain(1'b1);
    push_sequence(i2cme_pkg::CMD_STOP, 8'h00, 1'b0, SDA_RAND, -1, n);

    // zero phase length behaves as one tick
    set_phase_len(16'd0);
    push_sequence(i2cme_pkg::CMD_START, 8'h00, 1'b0, SDA_RAND, -1, n);
    push_sequence(i2cme_pkg::CMD_READ, 8'h00, 1'b0, SDA_RAND, -1, n);
    push_sequence(i2cme_pkg::CMD_WRITE, 8'h5A, 1'b0, SDA_RAND, -1, n);

    // random commands over short phase lengths
    set_phase_len(16'd1);
    random_run(120);
    set_phase_len(16'($urandom_range(2, 4)));
    random_run(120);
    set_phase_len(16'($urandom_range(1, 3)));
    random_run(120);

    // longest phase: only the opening ticks of a start
    set_phase_len(16'hFFFF);
    push_sequence(i2cme_pkg::CMD_START, 8'h00, 1'b0, SDA_RAND, 30, n);
    drain(1'b0);
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
